FILE: src/cplp_pkg.sv
`timescale 1ns / 1ps
// Package for the checksummed position line parser.
// Byte codes, line limits, value-token phase type and byte decoders; no dependencies.

package cplp_pkg;

  localparam int unsigned RxWidth  = 8;
  localparam int unsigned PosWidth = 32;

  // Byte codes of interest.
  localparam logic [RxWidth-1:0] ChrCr    = 8'd13;
  localparam logic [RxWidth-1:0] ChrNl    = 8'd10;
  localparam logic [RxWidth-1:0] ChrSpace = 8'd32;
  localparam logic [RxWidth-1:0] ChrTab   = 8'd9;
  localparam logic [RxWidth-1:0] ChrVtab  = 8'd11;
  localparam logic [RxWidth-1:0] ChrFf    = 8'd12;
  localparam logic [RxWidth-1:0] ChrPlus  = 8'd43;
  localparam logic [RxWidth-1:0] ChrMinus = 8'd45;

  // Line acceptance limits.
  localparam logic [2:0]  MinLineLen   = 3'd7;
  localparam logic [1:0]  CountSat     = 2'd3;
  localparam logic [1:0]  TailLen      = 2'd2;
  localparam logic [15:0] ChecksumBias = 16'd32;

  // Largest magnitude the value accumulator may hold (that of the most negative value).
  localparam logic [35:0] ValueMagLimit = 36'h0_8000_0000;

  typedef enum logic [1:0] {
    PhLead   = 2'd0,
    PhSign   = 2'd1,
    PhDigits = 2'd2,
    PhTrail  = 2'd3
  } val_phase_e;

  function automatic logic is_blank(input logic [RxWidth-1:0] c);
    return (c == ChrTab) || (c == ChrVtab) || (c == ChrFf);
  endfunction

  function automatic logic is_dec(input logic [RxWidth-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [RxWidth-1:0] c);
    logic [7:0] t;
    t = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

FILE: src/cplp_rx_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one received byte.
// Uses cplp_pkg for the field width.

interface cplp_rx_if;
  logic                          valid;
  logic                          ready;
  logic [cplp_pkg::RxWidth-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/cplp_pos_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one decoded position.
// Uses cplp_pkg for the field width.

interface cplp_pos_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cplp_pkg::PosWidth-1:0] position_steps;

  modport source (output valid, output position_steps, input ready);
  modport sink   (input valid, input position_steps, output ready);
endinterface

FILE: src/checksummed_position_line_parser_core.sv
`timescale 1ns / 1ps
// Top level of the checksummed position line parser.
// Depends on cplp_pkg, cplp_rx_if and cplp_pos_if.

// The parser takes one byte per clock cycle, no gaps required, while input
// ready is high. Each byte updates a small set of running line registers
// (length, space count, checksum sum, decimal and hex accumulators) through
// one level of short logic. When a newline is taken and the line passes the
// length, space and checksum checks, the decoded position goes into an output
// register backed by a one-entry skid buffer, so input keeps being taken while
// a result waits; input ready drops only when both are full. Carriage returns
// are ignored; lines failing these checks emit nothing; a bad value emits zero.

module checksummed_position_line_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  cplp_rx_if.sink    rx_i,
  cplp_pos_if.source pos_o
);

  // Line state.
  logic [2:0]             line_len_q, line_len_d;
  logic [1:0]             space_cnt_q, space_cnt_d;
  logic [1:0]             tail_len_q, tail_len_d;
  logic [15:0]            char_sum_q, char_sum_d;
  logic [31:0]            val_acc_q, val_acc_d;
  cplp_pkg::val_phase_e   val_phase_q, val_phase_d;
  logic                   val_neg_q, val_neg_d;
  logic                   val_bad_q, val_bad_d;
  logic [7:0]             hex_acc_q, hex_acc_d;
  logic                   hex_have_q, hex_have_d;
  logic                   hex_neg_q, hex_neg_d;
  logic                   hex_pend_q, hex_pend_d;

  // Output register and skid stage.
  logic                   out_valid_q, out_valid_d;
  logic signed [31:0]     out_data_q, out_data_d;
  logic                   skid_valid_q, skid_valid_d;
  logic signed [31:0]     skid_data_q, skid_data_d;

  logic                   in_fire, out_fire;
  logic [7:0]             c;
  logic                   is_cr, is_nl, is_sp, blank, dec;
  logic [4:0]             hex_dig;
  logic [35:0]            val_next;
  logic [7:0]             neg_sum;
  logic signed [9:0]      sum_mod, msg_val;
  logic                   line_ok, sum_ok, val_good, emit;
  logic signed [31:0]     result;

  assign in_fire  = rx_i.valid && rx_i.ready;
  assign out_fire = out_valid_q && pos_o.ready;
  assign rx_i.ready = !skid_valid_q;

  assign c       = rx_i.rx_byte;
  assign is_cr   = (c == cplp_pkg::ChrCr);
  assign is_nl   = (c == cplp_pkg::ChrNl);
  assign is_sp   = (c == cplp_pkg::ChrSpace);
  assign blank   = cplp_pkg::is_blank(c);
  assign dec     = cplp_pkg::is_dec(c);
  assign hex_dig = cplp_pkg::hex_decode(c);

  // acc * 10 + digit, as two shifts and two adds.
  assign val_next = {1'b0, val_acc_q, 3'b000} + {3'b000, val_acc_q, 1'b0}
                  + {32'd0, c[3:0]};

  // Truncating remainder of the signed sum by 256.
  assign neg_sum = 8'd0 - char_sum_q[7:0];
  assign sum_mod = char_sum_q[15] ? (10'sd0 - $signed({2'b00, neg_sum}))
                                  : $signed({2'b00, char_sum_q[7:0]});
  assign msg_val = hex_neg_q ? (10'sd0 - $signed({2'b00, hex_acc_q}))
                             : $signed({2'b00, hex_acc_q});

  assign line_ok = (line_len_q >= cplp_pkg::MinLineLen) && (space_cnt_q == 2'd1)
                && (tail_len_q == cplp_pkg::TailLen) && hex_have_q;
  assign sum_ok  = (sum_mod == msg_val);
  assign val_good = !val_bad_q
                 && ((val_phase_q == cplp_pkg::PhDigits) || (val_phase_q == cplp_pkg::PhTrail))
                 && (val_neg_q || !val_acc_q[31]);
  assign result  = !val_good ? 32'sd0
                 : val_neg_q ? $signed(32'd0 - val_acc_q) : $signed(val_acc_q);
  assign emit    = in_fire && is_nl && line_ok && sum_ok;

  always_comb begin
    line_len_d  = line_len_q;
    space_cnt_d = space_cnt_q;
    tail_len_d  = tail_len_q;
    char_sum_d  = char_sum_q;
    val_acc_d   = val_acc_q;
    val_phase_d = val_phase_q;
    val_neg_d   = val_neg_q;
    val_bad_d   = val_bad_q;
    hex_acc_d   = hex_acc_q;
    hex_have_d  = hex_have_q;
    hex_neg_d   = hex_neg_q;
    hex_pend_d  = hex_pend_q;

    if (in_fire && !is_cr) begin
      if (is_nl) begin
        line_len_d  = 3'd0;
        space_cnt_d = 2'd0;
        tail_len_d  = 2'd0;
        char_sum_d  = cplp_pkg::ChecksumBias;
        val_acc_d   = 32'd0;
        val_phase_d = cplp_pkg::PhLead;
        val_neg_d   = 1'b0;
        val_bad_d   = 1'b0;
        hex_acc_d   = 8'd0;
        hex_have_d  = 1'b0;
        hex_neg_d   = 1'b0;
        hex_pend_d  = 1'b0;
      end else begin
        if (line_len_q < cplp_pkg::MinLineLen) begin
          line_len_d = line_len_q + 3'd1;
        end
        if (is_sp) begin
          if (space_cnt_q < cplp_pkg::CountSat) begin
            space_cnt_d = space_cnt_q + 2'd1;
          end
        end else if (space_cnt_q == 2'd0) begin
          char_sum_d = char_sum_q + {{8{c[7]}}, c};
          // Value token: blanks, optional sign, digits, blanks.
          if (!val_bad_q) begin
            if (dec && (val_phase_q != cplp_pkg::PhTrail)) begin
              if (val_next > cplp_pkg::ValueMagLimit) begin
                val_bad_d = 1'b1;
              end else begin
                val_acc_d   = val_next[31:0];
                val_phase_d = cplp_pkg::PhDigits;
              end
            end else if (blank && (val_phase_q != cplp_pkg::PhSign)) begin
              if (val_phase_q != cplp_pkg::PhLead) begin
                val_phase_d = cplp_pkg::PhTrail;
              end
            end else if (((c == cplp_pkg::ChrPlus) || (c == cplp_pkg::ChrMinus))
                         && (val_phase_q == cplp_pkg::PhLead)) begin
              val_phase_d = cplp_pkg::PhSign;
              val_neg_d   = (c == cplp_pkg::ChrMinus);
            end else begin
              val_bad_d = 1'b1;
            end
          end
        end else if (space_cnt_q == 2'd1) begin
          if (tail_len_q == 2'd0) begin
            if (hex_dig[4]) begin
              hex_acc_d  = {4'd0, hex_dig[3:0]};
              hex_have_d = 1'b1;
              hex_neg_d  = 1'b0;
              hex_pend_d = 1'b0;
            end else if (blank || (c == cplp_pkg::ChrPlus)) begin
              hex_have_d = 1'b0;
              hex_neg_d  = 1'b0;
              hex_pend_d = 1'b1;
            end else if (c == cplp_pkg::ChrMinus) begin
              hex_have_d = 1'b0;
              hex_neg_d  = 1'b1;
              hex_pend_d = 1'b1;
            end else begin
              hex_have_d = 1'b0;
              hex_neg_d  = 1'b0;
              hex_pend_d = 1'b0;
            end
          end else if (tail_len_q == 2'd1) begin
            // A digit after a lone leading digit extends it; a non-digit keeps it.
            if (hex_have_q) begin
              if (hex_dig[4]) begin
                hex_acc_d = {hex_acc_q[3:0], hex_dig[3:0]};
              end
            end else if (hex_pend_q) begin
              if (hex_dig[4]) begin
                hex_acc_d  = {4'd0, hex_dig[3:0]};
                hex_have_d = 1'b1;
                hex_pend_d = 1'b0;
              end else begin
                hex_have_d = 1'b0;
                hex_neg_d  = 1'b0;
                hex_pend_d = 1'b0;
              end
            end
          end
          if (tail_len_q < cplp_pkg::CountSat) begin
            tail_len_d = tail_len_q + 2'd1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_q || out_fire) begin
        out_valid_d = 1'b1;
        out_data_d  = result;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = result;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  assign pos_o.valid          = out_valid_q;
  assign pos_o.position_steps = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q   <= 3'd0;
      space_cnt_q  <= 2'd0;
      tail_len_q   <= 2'd0;
      char_sum_q   <= cplp_pkg::ChecksumBias;
      val_acc_q    <= 32'd0;
      val_phase_q  <= cplp_pkg::PhLead;
      val_neg_q    <= 1'b0;
      val_bad_q    <= 1'b0;
      hex_acc_q    <= 8'd0;
      hex_have_q   <= 1'b0;
      hex_neg_q    <= 1'b0;
      hex_pend_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      line_len_q   <= line_len_d;
      space_cnt_q  <= space_cnt_d;
      tail_len_q   <= tail_len_d;
      char_sum_q   <= char_sum_d;
      val_acc_q    <= val_acc_d;
      val_phase_q  <= val_phase_d;
      val_neg_q    <= val_neg_d;
      val_bad_q    <= val_bad_d;
      hex_acc_q    <= hex_acc_d;
      hex_have_q   <= hex_have_d;
      hex_neg_q    <= hex_neg_d;
      hex_pend_q   <= hex_pend_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  // The skid stage only fills behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  // A newline always leaves the line state cleared.
  a_nl_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_nl) |=> (line_len_q == 3'd0) && (char_sum_q == cplp_pkg::ChecksumBias)
                           && !hex_have_q && !val_bad_q)
    else $error("line state not cleared after newline");

  // A new result only appears after an accepted newline.
  a_result_after_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire && is_nl))
    else $error("result appeared without a terminating newline");

  // The decimal magnitude never grows past the most negative value.
  a_val_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !val_acc_q[31] || (val_acc_q[30:0] == 31'd0))
    else $error("value accumulator exceeded its limit");

  // Hex state: a digit is never pending once one has been taken.
  a_hex_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hex_have_q && hex_pend_q))
    else $error("hex digit both present and pending");

endmodule
